### rtl/fbbm_pkg.sv
// Package for the flasher/buzzer block with its button menu.
// Word types, register set, menu mode codes and the duty reciprocal constant.
// No dependencies; imported by every module under rtl.
package fbbm_pkg;

   // Field widths
   localparam int unsigned PeriodW = 10;
   localparam int unsigned BuzzW   = 8;
   localparam int unsigned DutyW   = 7;
   localparam int unsigned HoldW   = 8;
   localparam int unsigned ModeW   = 2;

   // Menu modes
   localparam logic [ModeW-1:0] MODE_NORMAL = 2'd0;
   localparam logic [ModeW-1:0] MODE_PERIOD = 2'd1;
   localparam logic [ModeW-1:0] MODE_BUZZ   = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_DUTY        = 3'd0;
   localparam logic [2:0] REG_MIN_PERIOD  = 3'd1;
   localparam logic [2:0] REG_MAX_PERIOD  = 3'd2;
   localparam logic [2:0] REG_MAX_BUZZ    = 3'd3;
   localparam logic [2:0] REG_MODE_HOLD   = 3'd4;
   localparam logic [2:0] REG_REPEAT_HOLD = 3'd5;

   // Register reset values
   localparam logic [DutyW-1:0]   DUTY_RESET        = 7'd50;
   localparam logic [PeriodW-1:0] MIN_PERIOD_RESET  = 10'd500;
   localparam logic [PeriodW-1:0] MAX_PERIOD_RESET  = 10'd1000;
   localparam logic [BuzzW-1:0]   MAX_BUZZ_RESET    = 8'd250;
   localparam logic [HoldW-1:0]   MODE_HOLD_RESET   = 8'd200;
   localparam logic [HoldW-1:0]   REPEAT_HOLD_RESET = 8'd10;

   // State reset values
   localparam logic [PeriodW-1:0] ON_LENGTH_RESET = 10'd400;
   localparam logic [PeriodW-1:0] PERIOD_RESET    = 10'd800;
   localparam logic [BuzzW-1:0]   BUZZ_RESET      = 8'd5;
   localparam logic [HoldW-1:0]   COUNT_MAX       = 8'hff;
   localparam logic [PeriodW-1:0] ON_LENGTH_MAX   = 10'd1023;

   // x / 100 == (x * DUTY_RECIP) >> DUTY_SHIFT, exact for x below 199728,
   // and period * duty stays below 129922
   localparam int unsigned  RecipW     = 18;
   localparam int unsigned  DutyKW     = DutyW + RecipW;
   localparam int unsigned  OnProdW    = PeriodW + DutyKW;
   localparam int unsigned  DUTY_SHIFT = 24;
   localparam logic [RecipW-1:0] DUTY_RECIP = 18'd167773;
   localparam logic [DutyKW-1:0] DUTY_K_RESET = DutyKW'(50 * 167773);

   // Input word
   typedef struct packed {
      logic minus_pressed;
      logic plus_pressed;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic               light_on;
      logic               buzzer_level;
      logic [ModeW-1:0]   menu_mode;
      logic [PeriodW-1:0] period_now;
      logic [BuzzW-1:0]   buzz_now;
      logic               save_request;
   } rsp_word_type;

   // Register set as seen by the datapath
   typedef struct packed {
      logic [DutyW-1:0]   duty_percent;
      logic [DutyKW-1:0]  duty_k;
      logic [PeriodW-1:0] min_period;
      logic [PeriodW-1:0] max_period;
      logic [BuzzW-1:0]   max_buzz;
      logic [HoldW-1:0]   mode_hold;
      logic [HoldW-1:0]   repeat_hold;
   } cfg_type;

   // Flasher outputs for one tick
   typedef struct packed {
      logic light_on;
      logic buzzer_level;
   } flash_out_type;

   // Menu outputs for one tick, after the update
   typedef struct packed {
      logic [ModeW-1:0]   menu_mode;
      logic [PeriodW-1:0] period_length;
      logic [BuzzW-1:0]   buzz_length;
      logic               save_request;
   } menu_out_type;

endpackage

### rtl/fbbm_csr.sv
// Register file for the flasher block, written over an APB-style port.
// Also keeps duty_percent scaled by the reciprocal of 100 for the on-length product.
// Depends on fbbm_pkg.
module fbbm_csr
   import fbbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [DutyW-1:0]   duty_ff,        duty_in;
   logic [DutyKW-1:0]  duty_k_ff,      duty_k_in;
   logic [PeriodW-1:0] min_period_ff,  min_period_in;
   logic [PeriodW-1:0] max_period_ff,  max_period_in;
   logic [BuzzW-1:0]   max_buzz_ff,    max_buzz_in;
   logic [HoldW-1:0]   mode_hold_ff,   mode_hold_in;
   logic [HoldW-1:0]   repeat_hold_ff, repeat_hold_in;
   logic               wr_en;
   logic [2:0]         reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   // Decode the write
   always_comb begin
      duty_in        = duty_ff;
      duty_k_in      = duty_k_ff;
      min_period_in  = min_period_ff;
      max_period_in  = max_period_ff;
      max_buzz_in    = max_buzz_ff;
      mode_hold_in   = mode_hold_ff;
      repeat_hold_in = repeat_hold_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DUTY: begin
               duty_in   = csr_pwdata[DutyW-1:0];
               duty_k_in = DutyKW'(csr_pwdata[DutyW-1:0]) * DutyKW'(DUTY_RECIP);
            end
            REG_MIN_PERIOD:  min_period_in  = csr_pwdata[PeriodW-1:0];
            REG_MAX_PERIOD:  max_period_in  = csr_pwdata[PeriodW-1:0];
            REG_MAX_BUZZ:    max_buzz_in    = csr_pwdata[BuzzW-1:0];
            REG_MODE_HOLD:   mode_hold_in   = csr_pwdata[HoldW-1:0];
            REG_REPEAT_HOLD: repeat_hold_in = csr_pwdata[HoldW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff        <= DUTY_RESET;
         duty_k_ff      <= DUTY_K_RESET;
         min_period_ff  <= MIN_PERIOD_RESET;
         max_period_ff  <= MAX_PERIOD_RESET;
         max_buzz_ff    <= MAX_BUZZ_RESET;
         mode_hold_ff   <= MODE_HOLD_RESET;
         repeat_hold_ff <= REPEAT_HOLD_RESET;
      end else begin
         duty_ff        <= duty_in;
         duty_k_ff      <= duty_k_in;
         min_period_ff  <= min_period_in;
         max_period_ff  <= max_period_in;
         max_buzz_ff    <= max_buzz_in;
         mode_hold_ff   <= mode_hold_in;
         repeat_hold_ff <= repeat_hold_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_DUTY:        csr_prdata = 32'(duty_ff);
         REG_MIN_PERIOD:  csr_prdata = 32'(min_period_ff);
         REG_MAX_PERIOD:  csr_prdata = 32'(max_period_ff);
         REG_MAX_BUZZ:    csr_prdata = 32'(max_buzz_ff);
         REG_MODE_HOLD:   csr_prdata = 32'(mode_hold_ff);
         REG_REPEAT_HOLD: csr_prdata = 32'(repeat_hold_ff);
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg.duty_percent = duty_ff;
   assign cfg.duty_k       = duty_k_ff;
   assign cfg.min_period   = min_period_ff;
   assign cfg.max_period   = max_period_ff;
   assign cfg.max_buzz     = max_buzz_ff;
   assign cfg.mode_hold    = mode_hold_ff;
   assign cfg.repeat_hold  = repeat_hold_ff;

endmodule

### rtl/fbbm_flasher.sv
// Flasher and buzzer: tick counter, on length and buzzer toggle state.
// Updates once per advanced tick using the period and buzz length before the menu runs.
// Depends on fbbm_pkg.
module fbbm_flasher
   import fbbm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [DutyKW-1:0]  duty_k,
   input  logic [PeriodW-1:0] period_length,
   input  logic [BuzzW-1:0]   buzz_length,
   output flash_out_type      flash_out
);

   logic [PeriodW-1:0] tick_ff,   tick_in;
   logic [PeriodW-1:0] on_len_ff, on_len_in;
   logic               buzz_ff,   buzz_in;
   logic [PeriodW:0]   tick_inc;
   logic [PeriodW:0]   off_ticks;
   logic [OnProdW-1:0] on_prod;
   logic [OnProdW-DUTY_SHIFT-1:0] on_quot;
   logic               light;
   logic               sound;
   logic               wrap;

   // Count and phase
   always_comb begin
      tick_inc  = {1'b0, tick_ff} + 1'b1;
      light     = tick_inc < {1'b0, on_len_ff};
      off_ticks = tick_inc - {1'b0, on_len_ff};
      sound     = light ? (tick_inc < (PeriodW + 1)'(buzz_length))
                        : (off_ticks < (PeriodW + 1)'(buzz_length));
      wrap      = tick_inc >= {1'b0, period_length};
   end

   // On length = period * duty / 100, saturated
   always_comb begin
      on_prod = OnProdW'(period_length) * OnProdW'(duty_k);
      on_quot = on_prod[OnProdW-1:DUTY_SHIFT];
      if (on_quot > (OnProdW - DUTY_SHIFT)'(ON_LENGTH_MAX)) begin
         on_len_in = ON_LENGTH_MAX;
      end else begin
         on_len_in = on_quot[PeriodW-1:0];
      end
      if (!wrap) begin
         on_len_in = on_len_ff;
      end
      tick_in = wrap ? '0 : tick_inc[PeriodW-1:0];
      buzz_in = sound ? ~buzz_ff : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         on_len_ff <= ON_LENGTH_RESET;
         buzz_ff   <= 1'b0;
      end else if (advance) begin
         tick_ff   <= tick_in;
         on_len_ff <= on_len_in;
         buzz_ff   <= buzz_in;
      end
   end

   assign flash_out.light_on     = light;
   assign flash_out.buzzer_level = buzz_in;

endmodule

### rtl/fbbm_menu.sv
// Button menu: scan divider, saturating press counters, mode, period and buzz length.
// Runs the scan on every SCAN_TICKS-th advanced tick with that tick's buttons.
// Depends on fbbm_pkg.
module fbbm_menu
   import fbbm_pkg::*;
#(
   parameter int unsigned SCAN_TICKS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  req_word_type       buttons,
   input  cfg_type            cfg,
   output logic [PeriodW-1:0] period_cur,
   output logic [BuzzW-1:0]   buzz_cur,
   output menu_out_type       menu_out
);

   localparam int unsigned DivW = (SCAN_TICKS > 1) ? $clog2(SCAN_TICKS) : 1;
   localparam logic [DivW-1:0] DivLast = DivW'(SCAN_TICKS - 1);

   logic [DivW-1:0]    div_ff,    div_in;
   logic [HoldW-1:0]   minus_ff,  minus_in;
   logic [HoldW-1:0]   plus_ff,   plus_in;
   logic [ModeW-1:0]   mode_ff,   mode_in;
   logic [PeriodW-1:0] period_ff, period_in;
   logic [BuzzW-1:0]   buzz_ff,   buzz_in;
   logic [HoldW-1:0]   minus_cnt;
   logic [HoldW-1:0]   plus_cnt;
   logic [ModeW-1:0]   mode_nxt;
   logic [PeriodW-1:0] period_nxt;
   logic [BuzzW-1:0]   buzz_nxt;
   logic               both_held;
   logic               scan_hit;
   logic               save;

   assign scan_hit = (div_ff == DivLast);

   // Menu scan
   always_comb begin
      // saturating press counters
      if (!buttons.minus_pressed) begin
         minus_cnt = '0;
      end else if (minus_ff != COUNT_MAX) begin
         minus_cnt = minus_ff + 1'b1;
      end else begin
         minus_cnt = minus_ff;
      end
      if (!buttons.plus_pressed) begin
         plus_cnt = '0;
      end else if (plus_ff != COUNT_MAX) begin
         plus_cnt = plus_ff + 1'b1;
      end else begin
         plus_cnt = plus_ff;
      end

      // both held long enough: advance the mode, save when wrapping
      both_held = (minus_cnt >= cfg.mode_hold) && (plus_cnt >= cfg.mode_hold);
      mode_nxt  = mode_ff;
      save      = 1'b0;
      if (both_held) begin
         minus_cnt = '0;
         plus_cnt  = '0;
         if (mode_ff == MODE_BUZZ) begin
            mode_nxt = MODE_NORMAL;
            save     = 1'b1;
         end else begin
            mode_nxt = mode_ff + 1'b1;
         end
      end

      // step the selected setting with a single held button
      period_nxt = period_ff;
      buzz_nxt   = buzz_ff;
      if ((mode_nxt != MODE_NORMAL) && !((minus_cnt != '0) && (plus_cnt != '0))) begin
         if (minus_cnt > cfg.repeat_hold) begin
            if (mode_nxt == MODE_PERIOD) begin
               if (period_ff < cfg.max_period) period_nxt = period_ff + 1'b1;
            end else if (buzz_ff != '0) begin
               buzz_nxt = buzz_ff - 1'b1;
            end
         end else if (plus_cnt > cfg.repeat_hold) begin
            if (mode_nxt == MODE_PERIOD) begin
               if (period_ff > cfg.min_period) period_nxt = period_ff - 1'b1;
            end else if (buzz_ff < cfg.max_buzz) begin
               buzz_nxt = buzz_ff + 1'b1;
            end
         end
      end
   end

   // Apply on scan ticks only
   always_comb begin
      if (scan_hit) begin
         div_in    = '0;
         minus_in  = minus_cnt;
         plus_in   = plus_cnt;
         mode_in   = mode_nxt;
         period_in = period_nxt;
         buzz_in   = buzz_nxt;
      end else begin
         div_in    = div_ff + 1'b1;
         minus_in  = minus_ff;
         plus_in   = plus_ff;
         mode_in   = mode_ff;
         period_in = period_ff;
         buzz_in   = buzz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff    <= '0;
         minus_ff  <= '0;
         plus_ff   <= '0;
         mode_ff   <= MODE_NORMAL;
         period_ff <= PERIOD_RESET;
         buzz_ff   <= BUZZ_RESET;
      end else if (advance) begin
         div_ff    <= div_in;
         minus_ff  <= minus_in;
         plus_ff   <= plus_in;
         mode_ff   <= mode_in;
         period_ff <= period_in;
         buzz_ff   <= buzz_in;
      end
   end

   assign period_cur             = period_ff;
   assign buzz_cur               = buzz_ff;
   assign menu_out.menu_mode     = mode_in;
   assign menu_out.period_length = period_in;
   assign menu_out.buzz_length   = buzz_in;
   assign menu_out.save_request  = scan_hit && save;

endmodule

### rtl/flasher_buzzer_with_button_menu.sv
// Top level of the flasher/buzzer block with button menu: input register,
// result register and the flasher, menu and register-file units.
// Depends on fbbm_pkg, fbbm_csr, fbbm_flasher and fbbm_menu.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-------------------------------
//   req     | in        | req_valid / req_stall   | req_word_type (two buttons)
//   rsp     | out       | rsp_valid / rsp_stall   | rsp_word_type (lamp, buzzer, menu)
//   csr     | in        | APB psel/penable/pready | six registers at 4*i
//
// One word per cycle sustained while rsp is not stalled; a word passes through the
// input register, then the tick update into the result register. The input
// register drains into the result register whenever that register is empty or
// being taken, so a waiting result does not block the next word. Synchronous
// reset clears the valid flags and unit state, not the payload registers.
// A stall on rsp backs up through req_stall only once both registers are full.
module flasher_buzzer_with_button_menu
   import fbbm_pkg::*;
#(
   parameter int unsigned SCAN_TICKS = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type       cfg;
   flash_out_type flash_out;
   menu_out_type  menu_out;
   logic [PeriodW-1:0] period_cur;
   logic [BuzzW-1:0]   buzz_cur;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         advance;
   logic         req_take;

   // Handshake: move input register into result register when there is room
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      out_word_in.light_on     = flash_out.light_on;
      out_word_in.buzzer_level = flash_out.buzzer_level;
      out_word_in.menu_mode    = menu_out.menu_mode;
      out_word_in.period_now   = menu_out.period_length;
      out_word_in.buzz_now     = menu_out.buzz_length;
      out_word_in.save_request = menu_out.save_request;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   fbbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fbbm_flasher u_flasher (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .duty_k        (cfg.duty_k),
      .period_length (period_cur),
      .buzz_length   (buzz_cur),
      .flash_out     (flash_out)
   );

   fbbm_menu #(
      .SCAN_TICKS (SCAN_TICKS)
   ) u_menu (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .buttons    (in_word_ff),
      .cfg        (cfg),
      .period_cur (period_cur),
      .buzz_cur   (buzz_cur),
      .menu_out   (menu_out)
   );

   // Assertions
   a_save_leaves_menu: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.save_request) |-> (out_word_ff.menu_mode == MODE_NORMAL))
      else $error("save pulse without return to normal mode");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.menu_mode <= MODE_BUZZ))
      else $error("menu mode out of range");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall))
      else $error("input stalled while result register has room");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word lost from result register");

endmodule
